// ===== rtl/rc_pulse_width_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// RC pulse width decoder assertion macros
// Concurrent check wrappers clocked on clk with the active-low reset masked.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_WIDTH_DECODER_TOP_DEFINES_SVH
`define RC_PULSE_WIDTH_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// holds in the same cycle
`define RCPWD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent this cycle, consequent next cycle
`define RCPWD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCPWD_ASSERT(label, prop, msg)
`define RCPWD_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/rcpwd_pkg.sv =====
// ----------------------------------------------------------------------------
// RC pulse width decoder package
// Shared widths, reset values, codes and the mapping unit interface types.
// ----------------------------------------------------------------------------
package rcpwd_pkg;

  localparam int CAPTURE_W        = 16;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int ANGLE_W          = 32;
  localparam int CAPTURE_BITS_DEF = 16;

  // serial mapping unit step counts
  localparam int MUL_STEPS = CFG_W;
  localparam int DIV_STEPS = ANGLE_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_DEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_BIAS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_NUM    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_THR = 3'd6;

  // register reset values
  localparam logic [CFG_W-1:0] RST_MIN_PULSE  = 16'd500;
  localparam logic [CFG_W-1:0] RST_MAX_PULSE  = 16'd2500;
  localparam logic [CFG_W-1:0] RST_MID_WIDTH  = 16'd1500;
  localparam logic [CFG_W-1:0] RST_MAP_DEN    = 16'd350;
  localparam logic [CFG_W-1:0] RST_ANGLE_BIAS = 16'd0;
  localparam logic [CFG_W-1:0] RST_MAP_NUM    = 16'd1500;
  localparam logic [CFG_W-1:0] RST_SWITCH_THR = 16'd1750;

  // channel codes
  localparam logic [1:0] CH_STEER = 2'd0;
  localparam logic [1:0] CH_BRAKE = 2'd1;
  localparam logic [1:0] CH_AUTON = 2'd2;
  localparam int         NUM_CH   = 3;

  typedef struct packed {
    logic             start;
    logic             neg;   // sign of (width - mid_width)
    logic [CFG_W-1:0] mag;   // magnitude of (width - mid_width)
  } map_req_t;

  typedef struct packed {
    logic               done;
    logic [ANGLE_W-1:0] angle;
  } map_rsp_t;

endpackage

// ===== rtl/rc_pulse_width_decoder_top.sv =====
// ----------------------------------------------------------------------------
// RC pulse width decoder top level
// Flow: a valid steering falling edge gets its angle from the bit-serial unit
//   (16 multiply + 32 divide steps); every other edge goes straight to emit.
// A new edge is accepted only when idle, once the last result has been emitted.
// Reset (sync, active low): registers to defaults, rise captures 0, brake 1.
// ----------------------------------------------------------------------------
`include "rc_pulse_width_decoder_top_defines.svh"

module rc_pulse_width_decoder_top #(
  parameter int CAPTURE_BITS = rcpwd_pkg::CAPTURE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_channel,
  input  logic                                   in_level,
  input  logic [rcpwd_pkg::CAPTURE_W-1:0]        in_capture,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_angle_valid,
  output logic signed [rcpwd_pkg::ANGLE_W-1:0]   out_angle,
  output logic                                   out_brake_on,
  output logic                                   out_auton_on,
  input  logic                                   cfg_wr_en,
  input  logic [rcpwd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rcpwd_pkg::CFG_W-1:0]            cfg_data
);
  import rcpwd_pkg::*;

  localparam int CapW = (CAPTURE_BITS < CAPTURE_W) ? CAPTURE_BITS : CAPTURE_W;
  localparam logic [CAPTURE_W:0]   CapOne  = 1;
  localparam logic [CAPTURE_W-1:0] CapMask = CAPTURE_W'((CapOne << CapW) - CapOne);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      min_pulse_r, max_pulse_r, mid_width_r, map_den_r;
  logic [CFG_W-1:0]      angle_bias_r, map_num_r, switch_thr_r;
  logic [CapW-1:0]       rise_cap_r   [NUM_CH];
  logic [CapW-1:0]       rise_cap_nxt [NUM_CH];
  logic                  brake_r, brake_nxt;
  logic                  auton_r, auton_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [ANGLE_W-1:0]    pend_angle_r, pend_angle_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_angle_valid_r;
  logic [ANGLE_W-1:0]    out_angle_r;
  logic                  out_brake_r, out_auton_r;

  logic                  accept;
  logic                  emit;
  logic [CAPTURE_W-1:0]  width;
  logic [CAPTURE_W:0]    diff;
  logic                  steer_ok;
  map_req_t              map_req;
  map_rsp_t              map_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pulse_r  <= RST_MIN_PULSE;
      max_pulse_r  <= RST_MAX_PULSE;
      mid_width_r  <= RST_MID_WIDTH;
      map_den_r    <= RST_MAP_DEN;
      angle_bias_r <= RST_ANGLE_BIAS;
      map_num_r    <= RST_MAP_NUM;
      switch_thr_r <= RST_SWITCH_THR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MIN_PULSE:  min_pulse_r  <= cfg_data;
        CFG_MAX_PULSE:  max_pulse_r  <= cfg_data;
        CFG_MID_WIDTH:  mid_width_r  <= cfg_data;
        CFG_MAP_DEN:    map_den_r    <= cfg_data;
        CFG_ANGLE_BIAS: angle_bias_r <= cfg_data;
        CFG_MAP_NUM:    map_num_r    <= cfg_data;
        CFG_SWITCH_THR: switch_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    width    = in_capture & CapMask;
    diff     = {1'b0, width} - {1'b0, mid_width_r};
    steer_ok = (in_channel == CH_STEER) && !in_level &&
               (rise_cap_r[CH_STEER] != '0) &&
               (width > min_pulse_r) && (width < max_pulse_r);
  end

  always_comb begin
    map_req.start = accept && steer_ok;
    map_req.neg   = diff[CAPTURE_W];
    map_req.mag   = diff[CAPTURE_W] ? CFG_W'(~diff + 1'b1) : diff[CFG_W-1:0];
  end

  rcpwd_map u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (map_req),
    .map_num    (map_num_r),
    .map_den    (map_den_r),
    .angle_bias (angle_bias_r),
    .rsp        (map_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    rise_cap_nxt   = rise_cap_r;
    brake_nxt      = brake_r;
    auton_nxt      = auton_r;
    pend_valid_nxt = pend_valid_r;
    pend_angle_nxt = pend_angle_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_level) begin
            for (int i = 0; i < NUM_CH; i++) begin
              if (in_channel == 2'(i)) begin
                rise_cap_nxt[i] = width[CapW-1:0];
              end
            end
          end else begin
            if (in_channel == CH_BRAKE && rise_cap_r[CH_BRAKE] != '0) begin
              brake_nxt = width > switch_thr_r;
            end
            if (in_channel == CH_AUTON && rise_cap_r[CH_AUTON] != '0) begin
              auton_nxt = width > switch_thr_r;
            end
          end
          pend_valid_nxt = steer_ok;
          pend_angle_nxt = '0;
          state_nxt      = steer_ok ? S_CALC : S_EMIT;
        end
      end
      S_CALC: begin
        if (map_rsp.done) begin
          pend_angle_nxt = map_rsp.angle;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register frees as soon as the consumer takes the transaction
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      brake_r     <= 1'b1;
      auton_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        rise_cap_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      brake_r     <= brake_nxt;
      auton_r     <= auton_nxt;
      out_valid_r <= out_valid_nxt;
      rise_cap_r  <= rise_cap_nxt;
    end
    pend_valid_r <= pend_valid_nxt;
    pend_angle_r <= pend_angle_nxt;
    if (emit) begin
      out_angle_valid_r <= pend_valid_r;
      out_angle_r       <= pend_angle_r;
      out_brake_r       <= brake_r;
      out_auton_r       <= auton_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_angle_valid = out_angle_valid_r;
  assign out_angle       = out_angle_r;
  assign out_brake_on    = out_brake_r;
  assign out_auton_on    = out_auton_r;

  `RCPWD_ASSERT_NXT(a_one_at_a_time, accept, !in_ready, "accepted while busy")
  `RCPWD_ASSERT(a_angle_zero, !(out_valid && !out_angle_valid) || out_angle == '0, "stale angle")
  `RCPWD_ASSERT(a_done_in_calc, !map_rsp.done || state_r == S_CALC, "map done outside calc")
  `RCPWD_ASSERT_NXT(a_emit_loads, emit, out_valid, "emit did not load output")

endmodule

// ===== rtl/rcpwd_map.sv =====
// ----------------------------------------------------------------------------
// RC pulse width decoder steering map unit
// Bit-serial signed (mag * map_num) / map_den + angle_bias, 32-bit wrap (map_den 0 gives angle_bias).
// ----------------------------------------------------------------------------
module rcpwd_map (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rcpwd_pkg::map_req_t               req,
  input  logic [rcpwd_pkg::CFG_W-1:0]       map_num,
  input  logic [rcpwd_pkg::CFG_W-1:0]       map_den,
  input  logic [rcpwd_pkg::CFG_W-1:0]       angle_bias,
  output rcpwd_pkg::map_rsp_t               rsp
);
  import rcpwd_pkg::*;

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_MUL  = 6'b000010,
    M_DIV  = 6'b000100,
    M_SIGN = 6'b001000,
    M_OFS  = 6'b010000,
    M_DONE = 6'b100000
  } map_state_t;

  map_state_t             state_r, state_nxt;
  logic [ANGLE_W-1:0]     acc_r, acc_nxt;     // product, then quotient
  logic [CFG_W-1:0]       md_r, md_nxt;       // multiplier bits, LSB first
  logic [CFG_W-1:0]       rem_r, rem_nxt;
  logic [STEP_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;

  logic [CFG_W:0]         mul_sum;
  logic [CFG_W:0]         div_shift;
  logic [CFG_W:0]         div_diff;
  logic                   div_ge;

  always_comb begin
    mul_sum   = {1'b0, acc_r[ANGLE_W-1:CFG_W]} +
                (md_r[0] ? {1'b0, map_num} : '0);
    div_shift = {rem_r, acc_r[ANGLE_W-1]};
    div_ge    = div_shift >= {1'b0, map_den};
    div_diff  = div_shift - {1'b0, map_den};
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    md_nxt    = md_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    case (state_r)
      M_IDLE: begin
        if (req.start) begin
          acc_nxt   = '0;
          md_nxt    = req.mag;
          neg_nxt   = req.neg;
          cnt_nxt   = '0;
          state_nxt = M_MUL;
        end
      end
      M_MUL: begin
        acc_nxt = {mul_sum, acc_r[CFG_W-1:1]};
        md_nxt  = md_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_CNT_W'(MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = M_DIV;
        end
      end
      M_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_nxt = div_ge ? div_diff[CFG_W-1:0] : div_shift[CFG_W-1:0];
        acc_nxt = {acc_r[ANGLE_W-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = M_SIGN;
        end
      end
      M_SIGN: begin
        if (map_den == '0) begin
          acc_nxt = '0;
        end else if (neg_r) begin
          acc_nxt = ~acc_r + 1'b1;
        end
        state_nxt = M_OFS;
      end
      M_OFS: begin
        acc_nxt   = acc_r + {{(ANGLE_W-CFG_W){1'b0}}, angle_bias};
        state_nxt = M_DONE;
      end
      M_DONE: begin
        state_nxt = M_IDLE;
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    acc_r <= acc_nxt;
    md_r  <= md_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done  = (state_r == M_DONE);
  assign rsp.angle = acc_r;

endmodule
